@@ hw/rtl/keyword_and_digraph_scanner_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyword and digraph scanner
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_AND_DIGRAPH_SCANNER_CORE_ASSERT_SVH
`define KEYWORD_AND_DIGRAPH_SCANNER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define KDSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kdsc: assertion failed");

// Checks a property on every rising clock edge, reset included.
`define KDSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kdsc: assertion failed");

`else

`define KDSC_ASSERT(lbl, clk, rst_n, prop)
`define KDSC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hw/rtl/kdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyword and digraph scanner package
// Shared types, the keyword table and small helper functions.
// ----------------------------------------------------------------------------
package kdsc_pkg;

    // Default configuration of the top level.
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;

    // Fixed field widths.
    localparam int TOTAL_BITS   = 32;
    localparam int ISSUE_BITS   = 32;
    localparam int KW_IDX_BITS  = 5;
    localparam int KW_COUNT     = 17;
    localparam int KW_MAX_LEN   = 9;
    localparam int KW_STR_BITS  = 8 * KW_MAX_LEN;
    localparam int LEN_BITS     = 4;

    // Reserved pair bytes and identifier helpers.
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [LEN_BITS-1:0] LEN_SAT = 4'd15;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // Pair codes.
    localparam logic PAIR_LT_LBRK = 1'b0;
    localparam logic PAIR_RBRK_GT = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_KEYWORD = 2'd0,
        KIND_PAIR    = 2'd1,
        KIND_TOTALS  = 2'd2
    } t_kind;

    // Keyword spellings, right-justified, first character highest.
    localparam logic [KW_STR_BITS-1:0] KW_STR [KW_COUNT] = '{
        KW_STR_BITS'("domain"),  KW_STR_BITS'("field"),   KW_STR_BITS'("given"),
        KW_STR_BITS'("prefer"),  KW_STR_BITS'("require"), KW_STR_BITS'("offer"),
        KW_STR_BITS'("force"),   KW_STR_BITS'("inspect"), KW_STR_BITS'("expect"),
        KW_STR_BITS'("verify"),  KW_STR_BITS'("effects"), KW_STR_BITS'("ir"),
        KW_STR_BITS'("transform"), KW_STR_BITS'("on"),    KW_STR_BITS'("where"),
        KW_STR_BITS'("matches"), KW_STR_BITS'("in")
    };

    localparam logic [LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd5, 4'd5, 4'd6, 4'd7, 4'd5, 4'd5, 4'd7, 4'd6,
        4'd6, 4'd7, 4'd2, 4'd9, 4'd2, 4'd5, 4'd7, 4'd2
    };

    // One queued record: an optional issue and an optional totals word.
    typedef struct packed {
        logic                   issue_valid;
        t_kind                  issue_kind;
        logic [ISSUE_BITS-1:0]  issue_pos;
        logic [KW_IDX_BITS-1:0] kw_idx;
        logic                   pair_which;
        logic                   tot_valid;
        logic [TOTAL_BITS-1:0]  idt;
        logic [TOTAL_BITS-1:0]  kwt;
    } t_record;

    // Front to queue.
    typedef struct packed {
        logic    push;
        t_record rec;
    } t_q_push;

    // Queue to back.
    typedef struct packed {
        logic    empty;
        t_record rec;
    } t_q_head;

    // Character of keyword k at word offset off; zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [LEN_BITS-1:0] off);
        logic [7:0] c;
        c = '0;
        if (off < KW_LEN[k]) begin
            c = KW_STR[k][8*(int'(KW_LEN[k]) - 1 - int'(off)) +: 8];
        end
        return c;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_word_start(input logic [7:0] b);
        return is_letter(b) || (b == CH_UNDER);
    endfunction

    function automatic logic is_word_cont(input logic [7:0] b);
        return is_word_start(b) || (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic [TOTAL_BITS-1:0] sat_inc(input logic [TOTAL_BITS-1:0] v);
        return (v == TOTAL_MAX) ? v : v + 1'b1;
    endfunction

endpackage

@@ hw/rtl/kdsc_in_if.sv @@
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one source byte and its end marker per word.
// ----------------------------------------------------------------------------
interface kdsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, output source_byte, output end_of_source, input ready);
    modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

@@ hw/rtl/kdsc_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one scanner result per word.
// ----------------------------------------------------------------------------
interface kdsc_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        result_kind;
    logic [kdsc_pkg::ISSUE_BITS-1:0]   issue_position;
    logic [kdsc_pkg::KW_IDX_BITS-1:0]  keyword_index;
    logic                              pair_which;
    logic [kdsc_pkg::TOTAL_BITS-1:0]   identifier_total;
    logic [kdsc_pkg::TOTAL_BITS-1:0]   keyword_use_total;
    logic                              last_result;

    modport source (
        output valid, output result_kind, output issue_position, output keyword_index,
        output pair_which, output identifier_total, output keyword_use_total,
        output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input issue_position, input keyword_index,
        input pair_which, input identifier_total, input keyword_use_total,
        input last_result, output ready
    );
endinterface

@@ hw/rtl/kdsc_front.sv @@
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts one byte per cycle while the queue has room, tracks the open word
// and its keyword candidates, detects reserved pairs and records results.
// ----------------------------------------------------------------------------
`include "keyword_and_digraph_scanner_core_assert.svh"

module kdsc_front #(
    parameter int POSITION_BITS = kdsc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    kdsc_in_if.sink             i_src,
    input  logic                i_q_full,
    output kdsc_pkg::t_q_push   o_push
);

    localparam int LOW_BITS = (POSITION_BITS < kdsc_pkg::ISSUE_BITS) ?
                              POSITION_BITS : kdsc_pkg::ISSUE_BITS;

    // Scanner state.
    logic                               r_bracket_en;
    logic [POSITION_BITS-1:0]           r_byte_pos;
    logic                               r_inside;
    logic [POSITION_BITS-1:0]           r_word_start;
    logic [kdsc_pkg::LEN_BITS-1:0]      r_len;
    logic [kdsc_pkg::KW_COUNT-1:0]      r_cand;
    logic [7:0]                         r_prev;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    r_word_total;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    r_kw_total;

    logic                               accept;
    logic [7:0]                         b;
    logic                               last;
    logic                               close_now;
    logic                               open_now;
    logic                               extend;
    logic                               close_word;
    logic [kdsc_pkg::KW_COUNT-1:0]      base_cand;
    logic [kdsc_pkg::LEN_BITS-1:0]      base_len;
    logic [kdsc_pkg::KW_COUNT-1:0]      filt_cand;
    logic [kdsc_pkg::LEN_BITS-1:0]      new_len;
    logic [kdsc_pkg::KW_COUNT-1:0]      m_cand;
    logic [kdsc_pkg::LEN_BITS-1:0]      m_len;
    logic                               kw_hit;
    logic [kdsc_pkg::KW_IDX_BITS-1:0]   kw_idx;
    logic [POSITION_BITS-1:0]           start_pos;
    logic [POSITION_BITS-1:0]           pair_pos;
    logic                               pair_lt;
    logic                               pair_gt;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    word_total_upd;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    kw_total_upd;

    // Handshake: take a byte whenever the queue has room.
    assign i_src.ready = !i_q_full;
    assign accept      = i_src.valid && i_src.ready;
    assign b           = i_src.source_byte;
    assign last        = i_src.end_of_source;

    // Word boundary classification.
    assign close_now = r_inside && !kdsc_pkg::is_word_cont(b);
    assign open_now  = !r_inside && kdsc_pkg::is_word_start(b);
    assign extend    = r_inside && kdsc_pkg::is_word_cont(b);

    assign base_cand = open_now ? '1 : r_cand;
    assign base_len  = open_now ? '0 : r_len;
    assign new_len   = (base_len == kdsc_pkg::LEN_SAT) ? base_len : base_len + 1'b1;

    // Candidate filter: keep keywords whose next character is this byte.
    always_comb begin
        for (int k = 0; k < kdsc_pkg::KW_COUNT; k++) begin
            filt_cand[k] = base_cand[k] && (base_len < kdsc_pkg::KW_LEN[k]) &&
                           (kdsc_pkg::kw_char(k, base_len) == b);
        end
    end

    // A word ends at a non-identifier byte, or at end of source if still open.
    assign close_word = close_now || (last && (extend || open_now));
    assign m_cand     = close_now ? r_cand : filt_cand;
    assign m_len      = close_now ? r_len  : new_len;
    assign start_pos  = open_now ? r_byte_pos : r_word_start;

    // Exact match: a surviving candidate whose length equals the word length.
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = 0; k < kdsc_pkg::KW_COUNT; k++) begin
            if (!kw_hit && close_word && m_cand[k] && (m_len == kdsc_pkg::KW_LEN[k])) begin
                kw_hit = 1'b1;
                kw_idx = kdsc_pkg::KW_IDX_BITS'(k);
            end
        end
    end

    // Reserved pair detection.
    assign pair_lt  = !r_bracket_en && (r_prev == kdsc_pkg::CH_LT) && (b == kdsc_pkg::CH_LBRK);
    assign pair_gt  = !r_bracket_en && (r_prev == kdsc_pkg::CH_RBRK) && (b == kdsc_pkg::CH_GT);
    assign pair_pos = r_byte_pos - POSITION_BITS'(1);

    // Running totals including this byte.
    assign word_total_upd = close_word ? kdsc_pkg::sat_inc(r_word_total) : r_word_total;
    assign kw_total_upd   = kw_hit ? kdsc_pkg::sat_inc(r_kw_total) : r_kw_total;

    // Record for the back end.
    always_comb begin
        o_push                = '0;
        o_push.push           = accept && (kw_hit || pair_lt || pair_gt || last);
        o_push.rec.issue_valid = kw_hit || pair_lt || pair_gt;
        o_push.rec.tot_valid  = last;
        o_push.rec.idt        = word_total_upd;
        o_push.rec.kwt        = kw_total_upd;
        if (kw_hit) begin
            o_push.rec.issue_kind = kdsc_pkg::KIND_KEYWORD;
            o_push.rec.issue_pos  = kdsc_pkg::ISSUE_BITS'(start_pos[LOW_BITS-1:0]);
            o_push.rec.kw_idx     = kw_idx;
        end else begin
            o_push.rec.issue_kind = kdsc_pkg::KIND_PAIR;
            o_push.rec.issue_pos  = kdsc_pkg::ISSUE_BITS'(pair_pos[LOW_BITS-1:0]);
            o_push.rec.pair_which = pair_gt ? kdsc_pkg::PAIR_RBRK_GT : kdsc_pkg::PAIR_LT_LBRK;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bracket_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_bracket_en <= i_cfg_wdata;
        end
    end

    // Scanner state update; end of source clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_inside     <= 1'b0;
            r_word_start <= '0;
            r_len        <= '0;
            r_cand       <= '0;
            r_prev       <= '0;
            r_word_total <= '0;
            r_kw_total   <= '0;
        end else if (accept) begin
            if (last) begin
                r_byte_pos   <= '0;
                r_inside     <= 1'b0;
                r_word_start <= '0;
                r_len        <= '0;
                r_cand       <= '0;
                r_prev       <= '0;
                r_word_total <= '0;
                r_kw_total   <= '0;
            end else begin
                r_byte_pos   <= r_byte_pos + POSITION_BITS'(1);
                r_prev       <= b;
                r_inside     <= extend || open_now;
                r_word_start <= start_pos;
                r_word_total <= word_total_upd;
                r_kw_total   <= kw_total_upd;
                if (extend || open_now) begin
                    r_cand <= filt_cand;
                    r_len  <= new_len;
                end else begin
                    r_cand <= '0;
                    r_len  <= '0;
                end
            end
        end
    end

    // End of source leaves a cleared scanner behind.
    `KDSC_ASSERT(a_clear_after_end, i_clk, i_rst_n, accept && last |=> r_byte_pos == '0 && !r_inside && r_word_total == '0 && r_kw_total == '0)
    // Outside a word there is no length and no candidate left over.
    `KDSC_ASSERT(a_idle_word_empty, i_clk, i_rst_n, !r_inside |-> r_len == '0 && r_cand == '0)

endmodule

@@ hw/rtl/kdsc_queue.sv @@
// ----------------------------------------------------------------------------
// Record queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "keyword_and_digraph_scanner_core_assert.svh"

module kdsc_queue #(
    parameter int DEPTH = kdsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kdsc_pkg::t_q_push   i_push,
    output logic                o_full,
    input  logic                i_pop,
    output kdsc_pkg::t_q_head   o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kdsc_pkg::t_record      r_mem [DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;

    logic                   do_push;
    logic                   do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.rec   = r_mem[r_rd_ptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The front end only pushes when there is room.
    `KDSC_ASSERT(a_no_push_when_full, i_clk, i_rst_n, i_push.push |-> !o_full)
    // The back end only pops a record that is there.
    `KDSC_ASSERT(a_no_pop_when_empty, i_clk, i_rst_n, i_pop |-> !o_head.empty)

endmodule

@@ hw/rtl/kdsc_back.sv @@
// ----------------------------------------------------------------------------
// Result back end
// Splits each queued record into one or two result words and holds them in
// an output register until the consumer takes them.
// ----------------------------------------------------------------------------
`include "keyword_and_digraph_scanner_core_assert.svh"

module kdsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kdsc_pkg::t_q_head   i_head,
    output logic                o_pop,
    kdsc_out_if.source          o_res
);

    logic                               r_out_valid;
    logic                               r_phase;
    kdsc_pkg::t_kind                    r_kind;
    logic [kdsc_pkg::ISSUE_BITS-1:0]    r_pos;
    logic [kdsc_pkg::KW_IDX_BITS-1:0]   r_idx;
    logic                               r_which;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    r_idt;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    r_kwt;
    logic                               r_last;

    logic                               n_out_valid;
    logic                               n_phase;
    kdsc_pkg::t_kind                    n_kind;
    logic [kdsc_pkg::ISSUE_BITS-1:0]    n_pos;
    logic [kdsc_pkg::KW_IDX_BITS-1:0]   n_idx;
    logic                               n_which;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    n_idt;
    logic [kdsc_pkg::TOTAL_BITS-1:0]    n_kwt;
    logic                               n_last;
    logic                               load;

    assign load = !r_out_valid || o_res.ready;

    // Pick the next word: the issue first, then the totals.
    always_comb begin
        n_out_valid = r_out_valid;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_which     = r_which;
        n_idt       = r_idt;
        n_kwt       = r_kwt;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = !i_head.empty;
            if (!i_head.empty) begin
                if (!r_phase && i_head.rec.issue_valid) begin
                    n_kind  = i_head.rec.issue_kind;
                    n_pos   = i_head.rec.issue_pos;
                    n_idx   = i_head.rec.kw_idx;
                    n_which = i_head.rec.pair_which;
                    n_idt   = '0;
                    n_kwt   = '0;
                    n_last  = !i_head.rec.tot_valid;
                    n_phase = i_head.rec.tot_valid;
                    o_pop   = !i_head.rec.tot_valid;
                end else begin
                    n_kind  = kdsc_pkg::KIND_TOTALS;
                    n_pos   = '0;
                    n_idx   = '0;
                    n_which = 1'b0;
                    n_idt   = i_head.rec.idt;
                    n_kwt   = i_head.rec.kwt;
                    n_last  = 1'b1;
                    n_phase = 1'b0;
                    o_pop   = 1'b1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_pos   <= n_pos;
        r_idx   <= n_idx;
        r_which <= n_which;
        r_idt   <= n_idt;
        r_kwt   <= n_kwt;
        r_last  <= n_last;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.result_kind       = r_kind;
    assign o_res.issue_position    = r_pos;
    assign o_res.keyword_index     = r_idx;
    assign o_res.pair_which        = r_which;
    assign o_res.identifier_total  = r_idt;
    assign o_res.keyword_use_total = r_kwt;
    assign o_res.last_result       = r_last;

    // Half-sent record: its totals word is still waiting at the queue head.
    `KDSC_ASSERT(a_phase_has_totals, i_clk, i_rst_n, r_phase |-> !i_head.empty && i_head.rec.tot_valid && i_head.rec.issue_valid)
    // A totals word always closes the results of its byte.
    `KDSC_ASSERT(a_totals_is_last, i_clk, i_rst_n, r_out_valid && r_kind == kdsc_pkg::KIND_TOTALS |-> r_last)

endmodule

@@ hw/rtl/keyword_and_digraph_scanner_core.sv @@
// ----------------------------------------------------------------------------
// Keyword and digraph scanner core
// Scans source text one byte per word, reports contextual keywords used as
// identifiers, reserved bracket pairs, and per-source totals.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_src     in         source_byte[7:0], end_of_source
//  o_res     out        result_kind, issue_position, keyword_index, pair_which,
//                       identifier_total, keyword_use_total, last_result
//  i_cfg_*   in         bracket_syntax_enabled (write enable and one data bit)
//
//  The front end takes one byte every cycle while the record queue has room.
//  A byte yields zero, one or two result words; the back end sends one word
//  per cycle while the consumer is ready, the issue word before the totals.
//  A byte's results pass through the record queue and the output register.
//  Reset is synchronous and active low; it clears scanner state, the queue
//  and the configuration register.
//  An output stall fills the queue, after which i_src.ready drops.
// ----------------------------------------------------------------------------
module keyword_and_digraph_scanner_core #(
    parameter int POSITION_BITS = kdsc_pkg::POSITION_BITS_DEFAULT,
    parameter int QUEUE_DEPTH   = kdsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    kdsc_in_if.sink     i_src,
    kdsc_out_if.source  o_res
);

    kdsc_pkg::t_q_push  q_push;
    kdsc_pkg::t_q_head  q_head;
    logic               q_full;
    logic               q_pop;

    // Byte classification and scanner state.
    kdsc_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_src       (i_src),
        .i_q_full    (q_full),
        .o_push      (q_push)
    );

    // Decoupling queue.
    kdsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // Result serialization.
    kdsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

@@ bench/keyword_and_digraph_scanner_core_test.sv @@
// ----------------------------------------------------------------------------
// Keyword and digraph scanner core testbench
// Feeds source text through the byte channel with random gaps and output
// stalls, predicts every result word from an independent scanner model, and
// compares each received word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module keyword_and_digraph_scanner_core_test;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        logic       drain_first;
    } t_src_item;

    typedef struct {
        kdsc_pkg::t_kind kind;
        logic [31:0]     pos;
        logic [4:0]      kw;
        logic            which;
        logic [31:0]     words;
        logic [31:0]     kw_uses;
        logic            last;
    } t_scan_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    kdsc_in_if  src_ch ();
    kdsc_out_if res_ch ();

    keyword_and_digraph_scanner_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_src       (src_ch),
        .o_res       (res_ch)
    );

    string keyword_text [kdsc_pkg::KW_COUNT] = '{
        "domain", "field", "given", "prefer", "require", "offer", "force",
        "inspect", "expect", "verify", "effects", "ir", "transform", "on",
        "where", "matches", "in"
    };

    localparam string START_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string DIGIT_CHARS = "0123456789";
    localparam string SEP_CHARS   = " \t\n,;(){}=+-.*/<>[]";

    t_src_item    byte_backlog [$];
    t_scan_result due_results  [$];

    int   send_idle_pct;
    int   recv_idle_pct;
    int   fault_count;
    logic byte_taken;
    logic pause_pending;

    // Scanner state mirrored from the block.
    logic          bracket_en;
    logic [31:0]   scan_pos;
    logic          in_word;
    logic [31:0]   word_start;
    logic [3:0]    word_len;
    logic [16:0]   candidates;
    logic [7:0]    prev_ch;
    logic [31:0]   word_count;
    logic [31:0]   kw_count;
    t_scan_result  fresh [2];
    int            fresh_n;

    // Clock with a period of two time units.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic starts_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic extends_word(input logic [7:0] c);
        return starts_word(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == kdsc_pkg::TOTAL_MAX) ? v : v + 32'd1;
    endfunction

    function automatic t_scan_result blank_result(input kdsc_pkg::t_kind kind);
        t_scan_result r;
        r.kind    = kind;
        r.pos     = '0;
        r.kw      = '0;
        r.which   = 1'b0;
        r.words   = '0;
        r.kw_uses = '0;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic clear_scan();
        scan_pos   = '0;
        in_word    = 1'b0;
        word_start = '0;
        word_len   = '0;
        candidates = '0;
        prev_ch    = '0;
        word_count = '0;
        kw_count   = '0;
    endtask

    // Drop keywords whose character at the current word offset differs.
    task automatic narrow_candidates(input logic [7:0] c);
        for (int k = 0; k < kdsc_pkg::KW_COUNT; k++) begin
            if (int'(word_len) >= keyword_text[k].len() ||
                keyword_text[k][word_len] != c) begin
                candidates[k] = 1'b0;
            end
        end
        if (word_len != 4'd15) begin
            word_len = word_len + 4'd1;
        end
    endtask

    // Close the open word and report the first keyword that it spells.
    task automatic end_word();
        t_scan_result r;
        in_word    = 1'b0;
        word_count = bump(word_count);
        for (int k = 0; k < kdsc_pkg::KW_COUNT; k++) begin
            if (candidates[k] && keyword_text[k].len() == int'(word_len)) begin
                kw_count       = bump(kw_count);
                r              = blank_result(kdsc_pkg::KIND_KEYWORD);
                r.pos          = word_start;
                r.kw           = 5'(k);
                fresh[fresh_n] = r;
                fresh_n++;
                break;
            end
        end
        candidates = '0;
        word_len   = '0;
    endtask

    // Predict the result words of one accepted source byte.
    task automatic scan_byte(input logic [7:0] c, input logic eos);
        t_scan_result r;
        logic [31:0]  pos;
        pos     = scan_pos;
        fresh_n = 0;
        if (in_word) begin
            if (extends_word(c)) begin
                narrow_candidates(c);
            end else begin
                end_word();
            end
        end else if (starts_word(c)) begin
            in_word    = 1'b1;
            word_start = pos;
            word_len   = '0;
            candidates = '1;
            narrow_candidates(c);
        end

        // Reserved bracket pairs collide unless bracket syntax is on.
        if (!bracket_en) begin
            if ((prev_ch == kdsc_pkg::CH_LT && c == kdsc_pkg::CH_LBRK) ||
                (prev_ch == kdsc_pkg::CH_RBRK && c == kdsc_pkg::CH_GT)) begin
                r              = blank_result(kdsc_pkg::KIND_PAIR);
                r.pos          = pos - 32'd1;
                r.which        = (c == kdsc_pkg::CH_GT) ? kdsc_pkg::PAIR_RBRK_GT
                                                        : kdsc_pkg::PAIR_LT_LBRK;
                fresh[fresh_n] = r;
                fresh_n++;
            end
        end
        prev_ch  = c;
        scan_pos = pos + 32'd1;

        if (eos) begin
            if (in_word) begin
                end_word();
            end
            r              = blank_result(kdsc_pkg::KIND_TOTALS);
            r.words        = word_count;
            r.kw_uses      = kw_count;
            fresh[fresh_n] = r;
            fresh_n++;
            clear_scan();
        end

        if (fresh_n > 0) begin
            fresh[fresh_n-1].last = 1'b1;
        end
        for (int i = 0; i < fresh_n; i++) begin
            due_results = {due_results, fresh[i]};
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_word();
        t_scan_result want;
        if (due_results.size() == 0) begin
            $error("result word with no prediction: kind %0d position %0d",
                   res_ch.result_kind, res_ch.issue_position);
            fault_count++;
        end else begin
            want = due_results.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(res_ch.result_kind));
            compare_field("issue_position", want.pos, res_ch.issue_position);
            compare_field("keyword_index", 32'(want.kw), 32'(res_ch.keyword_index));
            compare_field("pair_which", 32'(want.which), 32'(res_ch.pair_which));
            compare_field("identifier_total", want.words, res_ch.identifier_total);
            compare_field("keyword_use_total", want.kw_uses, res_ch.keyword_use_total);
            compare_field("last_result", 32'(want.last), 32'(res_ch.last_result));
        end
    endtask

    // Monitor: check outgoing words, then predict from the accepted byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                check_word();
            end
            if (src_ch.valid && src_ch.ready) begin
                scan_byte(src_ch.source_byte, src_ch.end_of_source);
            end
            byte_taken <= src_ch.valid && src_ch.ready;
        end
    end

    // Driver: present the next byte once the current one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            src_ch.valid <= 1'b0;
        end else if (!src_ch.valid || byte_taken) begin
            if (byte_backlog.size() > 0 &&
                $urandom_range(99) >= send_idle_pct &&
                !(byte_backlog[0].drain_first && due_results.size() > 0)) begin
                src_ch.valid         <= 1'b1;
                src_ch.source_byte   <= byte_backlog[0].ch;
                src_ch.end_of_source <= byte_backlog[0].eos;
                void'(byte_backlog.pop_front());
            end else begin
                src_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic push_byte(input logic [7:0] c, input logic eos);
        t_src_item it;
        it.ch          = c;
        it.eos         = eos;
        it.drain_first = pause_pending;
        pause_pending  = 1'b0;
        byte_backlog   = {byte_backlog, it};
    endtask

    task automatic push_text(input string s, input logic eos_at_end);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], eos_at_end && i == s.len() - 1);
        end
    endtask

    function automatic string pick_char(input string pool);
        return string'(pool[$urandom_range(pool.len() - 1)]);
    endfunction

    // One token of source text; mostly words and separators.
    function automatic string make_token();
        string s;
        string kw;
        int    sel;
        int    n;
        sel = $urandom_range(99);
        kw  = keyword_text[$urandom_range(kdsc_pkg::KW_COUNT - 1)];
        s   = "";
        if (sel < 40) begin
            n = $urandom_range(99);
            if (n < 60) begin
                s = kw;
            end else if (n < 75) begin
                s = kw.substr(0, $urandom_range(kw.len() - 1));
            end else if (n < 90) begin
                s = {kw, pick_char({START_CHARS, DIGIT_CHARS})};
            end else begin
                s = {kw.substr(0, 0).toupper(), kw.substr(1, kw.len() - 1)};
            end
        end else if (sel < 55) begin
            // Some identifiers run past the saturation length.
            s = pick_char(START_CHARS);
            n = $urandom_range(19);
            for (int i = 0; i < n; i++) begin
                s = {s, pick_char({START_CHARS, DIGIT_CHARS})};
            end
        end else if (sel < 70) begin
            s = pick_char(SEP_CHARS);
        end else if (sel < 80) begin
            s = $urandom_range(1) ? "<[" : "]>";
        end else if (sel < 88) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                s = {s, pick_char(DIGIT_CHARS)};
            end
        end else begin
            s = string'(8'($urandom_range(255)));
        end
        return s;
    endfunction

    // Whole sources of random length until about count bytes are queued.
    task automatic queue_sources(input int count);
        string src;
        int    goal;
        int    queued;
        queued = 0;
        while (queued < count) begin
            goal = $urandom_range(1, 40);
            src  = "";
            while (src.len() < goal) begin
                src = {src, make_token()};
                if ($urandom_range(99) < 70) begin
                    src = {src, pick_char(SEP_CHARS)};
                end
            end
            // Push the source byte by byte; the last byte carries the end marker.
            for (int i = 0; i < src.len(); i++) begin
                push_byte(src[i], i == src.len() - 1);
            end
            queued += src.len();
        end
    endtask

    task automatic wait_drained();
        while (byte_backlog.size() != 0 || src_ch.valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_bracket_cfg(input logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        bracket_en   = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Main sequence of phases.
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = 1'b0;
        src_ch.valid         = 1'b0;
        src_ch.source_byte   = '0;
        src_ch.end_of_source = 1'b0;
        res_ch.ready         = 1'b0;
        fault_count          = 0;
        pause_pending        = 1'b0;
        bracket_en           = 1'b0;
        send_idle_pct        = 15;
        recv_idle_pct        = 57;
        clear_scan();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sources: both pairs, keyword at a pair, byte extremes,
        // non-ASCII bytes, keyword closed by the end marker, state clearing.
        write_bracket_cfg(1'b0);
        push_text("ir<[", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("]>", 1'b1);
        push_byte(8'h00, 1'b0);
        push_text("_on9", 1'b0);
        push_byte(8'h80, 1'b0);
        push_text("Z", 1'b1);
        push_text("on", 1'b1);
        push_text("<", 1'b1);
        push_text("[", 1'b1);
        push_text("force]>", 1'b1);
        queue_sources(150);
        wait_drained();

        write_bracket_cfg(1'b1);
        queue_sources(110);
        wait_drained();

        // Swap the idle ratios; halfway the sender holds until all is out.
        send_idle_pct = 57;
        recv_idle_pct = 15;
        write_bracket_cfg(1'b0);
        queue_sources(90);
        pause_pending = 1'b1;
        queue_sources(90);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_bracket_cfg(1'b1);
        queue_sources(50);
        wait_drained();

        write_bracket_cfg(1'b0);
        queue_sources(60);
        wait_drained();

        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
